/* src/pst_pkg.sv */
`default_nettype none

package pst_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int KIND_W        = 3;
    localparam int ID_W          = 31;
    localparam int STATUS_W      = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 3'd0,
        KIND_FORK   = 3'd1,
        KIND_EXIT   = 3'd2,
        KIND_REAP   = 3'd3,
        KIND_LOOKUP = 3'd4,
        KIND_CHILD  = 3'd5,
        KIND_COUNT  = 3'd6,
        KIND_CLEAR  = 3'd7
    } kind_t;

    // What a scan looks for
    typedef enum logic [1:0] {
        MODE_FIND_ID = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_REAP    = 2'd2,
        MODE_CHILD   = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // One slot entry as stored in the slot memory
    typedef struct packed {
        logic                exited;
        logic [ID_W-1:0]     id;
        logic [ID_W-1:0]     parent;
        logic [STATUS_W-1:0] status;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* src/process_slot_table.sv */
// Channel   Ports                          Transfer when
// -------   ----------------------------   ---------------------------
// request   start, busy, kind, pid,        rising edge with start high
//           status_in                      and busy low
// result    done, ok, value, status_out    rising edge ending the one
//                                          cycle that done is high
//
// One request at a time. A walk reads one slot per cycle through the single
// read port, and a fork walks twice. Count, clear and a create with the
// ids used up answer in the cycle after the transfer. Reset clears the used
// marks and the used count and sets the id counter to one; the slot memory
// is not cleared, as a slot's contents only count while it is marked used.
// The receiver cannot stall.
`default_nettype none

module process_slot_table #(
    parameter int SLOTS = pst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [pst_pkg::KIND_W-1:0]   kind,
    input  wire logic [pst_pkg::ID_W-1:0]     pid,
    input  wire logic [pst_pkg::STATUS_W-1:0] status_in,
    output logic                              done,
    output logic                              ok,
    output logic      [pst_pkg::ID_W-1:0]     value,
    output logic      [pst_pkg::STATUS_W-1:0] status_out
);

    import pst_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Control state
    state_t              state_reg,  state_next;
    mode_t               mode_reg,   mode_next;
    logic                done_reg,   done_next;
    logic [SLOTS-1:0]    used_reg,   used_next;
    logic [ID_W-1:0]     nid_reg,    nid_next;
    logic [CW-1:0]       count_reg,  count_next;
    logic [IW:0]         idx_reg,    idx_next;
    logic                chk_vld_reg, chk_vld_next;

    // Request and result payload
    kind_t               kind_reg,   kind_next;
    logic [ID_W-1:0]     pid_reg,    pid_next;
    logic [STATUS_W-1:0] stat_reg,   stat_next;
    logic [IW-1:0]       chk_idx_reg, chk_idx_next;
    logic                ok_reg,     ok_next;
    logic [ID_W-1:0]     value_reg,  value_next;
    logic [STATUS_W-1:0] sto_reg,    sto_next;

    // Slot memory port
    logic                rd_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    entry_t              wr_entry;
    entry_t              rd_entry;
    logic                used_bit;
    logic                hit;
    logic                scan_end;

    pst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (chk_idx_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);
    assign used_bit = used_reg[chk_idx_reg];
    // Nothing in flight and every slot read: the scan found nothing
    assign scan_end = (idx_reg == (IW+1)'(SLOTS)) && !chk_vld_reg;

    // Match test on the entry read back in this cycle
    always_comb
    begin
        case (mode_reg)
            MODE_FIND_ID: hit = used_bit && (rd_entry.id == pid_reg);
            MODE_FREE:    hit = !used_bit;
            MODE_REAP:    hit = used_bit && rd_entry.exited && (rd_entry.parent == pid_reg);
            MODE_CHILD:   hit = used_bit && (rd_entry.parent == pid_reg);
            default:      hit = 1'b0;
        endcase
        hit = hit && chk_vld_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        done_next    = 1'b0;
        used_next    = used_reg;
        nid_next     = nid_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        kind_next    = kind_reg;
        pid_next     = pid_reg;
        stat_next    = stat_reg;
        chk_idx_next = chk_idx_reg;
        ok_next      = ok_reg;
        value_next   = value_reg;
        sto_next     = sto_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_entry     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind_t'(kind);
                    pid_next   = pid;
                    stat_next  = status_in;
                    idx_next   = '0;
                    ok_next    = 1'b0;
                    value_next = '0;
                    sto_next   = '0;
                    case (kind_t'(kind))
                        KIND_CREATE:
                        begin
                            // Id counter exhausted: fail without a walk
                            if (nid_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                mode_next  = MODE_FREE;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_FORK, KIND_EXIT, KIND_LOOKUP:
                        begin
                            mode_next  = MODE_FIND_ID;
                            state_next = ST_SCAN;
                        end
                        KIND_REAP:
                        begin
                            mode_next  = MODE_REAP;
                            state_next = ST_SCAN;
                        end
                        KIND_CHILD:
                        begin
                            mode_next  = MODE_CHILD;
                            state_next = ST_SCAN;
                        end
                        KIND_COUNT:
                        begin
                            done_next  = 1'b1;
                            ok_next    = 1'b1;
                            value_next = ID_W'(count_reg);
                        end
                        default:
                        begin
                            // Clear: free every slot, restart ids
                            used_next  = '0;
                            nid_next   = ID_W'(1);
                            count_next = '0;
                            done_next  = 1'b1;
                            ok_next    = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue the next slot read while one is outstanding
                if (idx_reg != (IW+1)'(SLOTS))
                begin
                    rd_en        = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[IW-1:0];
                end

                if (hit)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    case (mode_reg)
                        MODE_FIND_ID:
                        begin
                            case (kind_reg)
                                KIND_FORK:
                                begin
                                    // Parent present: restart the walk for a free slot, or fail with the ids used up
                                    if (nid_reg == '0)
                                    begin
                                        ok_next = 1'b0;
                                    end
                                    else
                                    begin
                                        state_next   = ST_SCAN;
                                        done_next    = 1'b0;
                                        ok_next      = 1'b0;
                                        mode_next    = MODE_FREE;
                                        idx_next     = '0;
                                        chk_vld_next = 1'b0;
                                    end
                                end
                                KIND_EXIT:
                                begin
                                    wr_en           = 1'b1;
                                    wr_entry        = rd_entry;
                                    wr_entry.exited = 1'b1;
                                    wr_entry.status = stat_reg;
                                end
                                KIND_LOOKUP:
                                begin
                                    value_next = ID_W'(chk_idx_reg);
                                end
                                default:
                                begin
                                    ok_next = 1'b0;
                                end
                            endcase
                        end
                        MODE_FREE:
                        begin
                            wr_en           = 1'b1;
                            wr_entry.exited = 1'b0;
                            wr_entry.id     = nid_reg;
                            wr_entry.parent = (kind_reg == KIND_FORK) ? pid_reg : '0;
                            wr_entry.status = '0;
                            used_next[chk_idx_reg] = 1'b1;
                            count_next = count_reg + 1'b1;
                            nid_next   = nid_reg + 1'b1;
                            value_next = nid_reg;
                        end
                        MODE_REAP:
                        begin
                            used_next[chk_idx_reg] = 1'b0;
                            count_next = count_reg - 1'b1;
                            value_next = rd_entry.id;
                            sto_next   = rd_entry.status;
                        end
                        default:
                        begin
                            value_next = ID_W'(1);
                        end
                    endcase
                end
                else if (scan_end)
                begin
                    // No match; a child query still answers ok with flag 0
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = (kind_reg == KIND_CHILD);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FIND_ID;
            done_reg    <= 1'b0;
            used_reg    <= '0;
            nid_reg     <= ID_W'(1);
            count_reg   <= '0;
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            done_reg    <= done_next;
            used_reg    <= used_next;
            nid_reg     <= nid_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        pid_reg     <= pid_next;
        stat_reg    <= stat_next;
        chk_idx_reg <= chk_idx_next;
        ok_reg      <= ok_next;
        value_reg   <= value_next;
        sto_reg     <= sto_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign value      = value_reg;
    assign status_out = sto_reg;

    // A result only follows a request in flight or just transferred
    a_done_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a request");

    // Used count tracks the used marks
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(used_reg)))
        else $error("used count out of step with used marks");

    // Clear answers next cycle with an empty table and ids restarted
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_CLEAR)) |=>
            (done && ok && (count_reg == '0) && (nid_reg == ID_W'(1))))
        else $error("clear did not reset the table");

endmodule

`default_nettype wire

/* src/pst_ram.sv */
`default_nettype none

module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
